@@ rtl/core/xksc_pkg.sv @@
// shared types, constants and character mapping functions for the sextet text codec
// depends on nothing; used by xksc_ctrl, xksc_dp and the codec core
`default_nettype none

package xksc_pkg;

    localparam int FRAME_BYTES_DEF = 18;

    // register indexes, taken from paddr[2]
    localparam logic REG_DIRECTION = 1'b0;
    localparam logic REG_KEY_BYTE  = 1'b1;

    // direction register values
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    typedef enum logic
    {
        ST_IDLE,
        ST_EMIT
    } xksc_state_t;

    // controller to datapath
    typedef struct packed
    {
        logic take;   // accept the input request this cycle
        logic emit;   // load the next result into the output register
    } xksc_cmd_t;

    // datapath to controller
    typedef struct packed
    {
        logic burst;       // the next accepted request produces results
        logic item_done;   // the result loaded now is the last one of its request
        logic slot_free;   // output register can take a result
        logic frame_start; // frame position and lane are at zero
    } xksc_status_t;

    function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
        logic [7:0] w;
        w = {2'b00, s};
        if (w < 8'd27)
            return w + 8'd64;
        else if (w < 8'd53)
            return w + 8'd70;
        else
            return w - 8'd6;
    endfunction

    function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
        logic [7:0] w;
        w = 8'd0;
        if (c < 8'd47)
            w = 8'd0;
        else if (c < 8'd58)
            w = c + 8'd6;
        else if (c < 8'd64)
            w = 8'd0;
        else if (c < 8'd91)
            w = c - 8'd64;
        else if (c < 8'd97)
            w = 8'd0;
        else if (c < 8'd123)
            w = c - 8'd70;
        else
            w = 8'd0;
        return w[5:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/xor_keyed_sextet_text_codec_core.sv @@
// top level of the keyed sextet text codec: register port, controller and datapath
// depends on xksc_pkg, xksc_ctrl and xksc_dp
`default_nettype none

// Keyed sextet text codec. Frames of FRAME_BYTES bytes (default 18) travel in one of
// two directions, chosen by the direction register (0 encode, 1 decode). Encode takes
// FRAME_BYTES-1 plaintext bytes per frame, xors each with key_byte as it arrives and
// appends the key (as it stands at the last byte) as the final frame byte; each 3-byte
// group is packed little-endian into 24 bits and sent as four characters, lowest sextet
// first, with sextets 0-26 as '@'-'Z', 27-52 as 'a'-'z' and 53-63 as '/'-'9'. A short
// last group is zero-filled and still sent as four characters. Decode takes
// 4*ceil(FRAME_BYTES/3) characters (24 by default), maps anything outside the three
// ranges to sextet 0, rebuilds the frame in an internal byte store and, after the last
// character, sends bytes 0..FRAME_BYTES-2 xored with the final frame byte. tlast marks
// the final result of each frame. A request that closes nothing is simply taken. A
// request that closes an encode group is taken and then its four characters (eight at
// the frame end when FRAME_BYTES-1 is a multiple of three) leave through the output
// register one per cycle while m_tready is high; in decode the last character of a
// frame is followed by FRAME_BYTES-1 results. s_tready is low while a burst is being
// loaded, and the output register holds its result while m_tready is low. The next
// request is taken as soon as the last result of a burst sits in the output register.
// Writing the direction register starts a new frame; the byte store keeps its
// contents. Registers: direction at byte address 0, key_byte at 4; write them only
// while no frame result is pending.

module xor_keyed_sextet_text_codec_core
    import xksc_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input request stream
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    // result stream
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [7:0]  m_tdata,   // [7:0] out_byte
    output      logic        m_tlast,   // last
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    logic         direction_reg;
    logic         key_wr;
    logic [7:0]   key_value_reg;
    logic         cfg_wr;
    logic         clear_frame;
    xksc_cmd_t    dp_cmd;
    xksc_status_t dp_status;
    xksc_state_t  ctrl_state;

    // register writes complete in the access phase
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign clear_frame = cfg_wr && (paddr[2] == REG_DIRECTION);
    assign key_wr      = cfg_wr && (paddr[2] == REG_KEY_BYTE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_ENCODE;
            key_value_reg <= '0;
        end
        else
        begin
            if (clear_frame)
            begin
                direction_reg <= pwdata[0];
            end
            if (key_wr)
            begin
                key_value_reg <= pwdata[7:0];
            end
        end
    end

    // register read back
    always_comb
    begin
        if (paddr[2] == REG_KEY_BYTE)
        begin
            prdata = {24'b0, key_value_reg};
        end
        else
        begin
            prdata = {31'b0, direction_reg};
        end
    end

    // sequencing of accepts and result bursts
    xksc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (dp_cmd),
        .state    (ctrl_state)
    );

    // accumulator, byte store and output register
    xksc_dp #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (dp_cmd),
        .status      (dp_status),
        .direction   (direction_reg),
        .key_byte    (key_value_reg),
        .clear_frame (clear_frame),
        .in_byte     (s_tdata),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_byte    (m_tdata),
        .out_last    (m_tlast)
    );

    // a result is never loaded over one that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result loaded over a pending result");

    // accepting a request and loading a result never coincide
    a_take_excl_emit: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.take |-> !dp_cmd.emit)
        else $error("request accepted during a result burst");

    // a direction write starts a new frame
    a_dir_restart: assert property (@(posedge clk) disable iff (!rst_n)
        clear_frame |=> dp_status.frame_start)
        else $error("frame not restarted after direction write");

    // no request is taken while a burst is in progress
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_state == ST_EMIT) |-> !s_tready)
        else $error("ready raised during a result burst");

endmodule

`default_nettype wire

@@ rtl/core/xksc_ctrl.sv @@
// controller state machine of the sextet text codec: accept and result burst sequencing
// depends on xksc_pkg; drives the datapath through xksc_cmd_t
`default_nettype none

module xksc_ctrl
    import xksc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output      logic         s_tready,
    input  wire xksc_status_t status,
    output      xksc_cmd_t    cmd,
    output      xksc_state_t  state
);

    xksc_state_t state_reg;
    xksc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd.take   = 1'b0;
        cmd.emit   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
                if (s_tvalid && status.burst)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit = status.slot_free;
                if (status.slot_free && status.item_done)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    assign state = state_reg;

endmodule

`default_nettype wire

@@ rtl/core/xksc_dp.sv @@
// datapath of the sextet text codec: group accumulator, frame counters,
// decoded byte store, result shifter and output register; depends on xksc_pkg
`default_nettype none

module xksc_dp
    import xksc_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire xksc_cmd_t    cmd,
    output      xksc_status_t status,
    input  wire logic         direction,
    input  wire logic [7:0]   key_byte,
    input  wire logic         clear_frame,
    input  wire logic [7:0]   in_byte,
    input  wire logic         out_ready,
    output      logic         out_valid,
    output      logic [7:0]   out_byte,
    output      logic         out_last
);

    localparam int ROWS         = (FRAME_BYTES + 2) / 3;
    localparam int CHARS        = 4 * ROWS;
    localparam int POS_W        = $clog2(CHARS);
    localparam int ROW_W        = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ENC_LAST_POS = FRAME_BYTES - 2;
    localparam int DEC_LAST_POS = CHARS - 1;
    localparam int FIN_LANE     = (FRAME_BYTES - 1) % 3;
    localparam int RD_LAST_ROW  = (FRAME_BYTES - 2) / 3;
    localparam int RD_LAST_LANE = (FRAME_BYTES - 2) % 3;

    // frame state
    logic [23:0]      acc_reg,   acc_next;
    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [1:0]       lane3_reg, lane3_next;

    // encode result shifter
    logic [23:0]      shift_reg, shift_next;
    logic [1:0]       sext_reg,  sext_next;
    logic             key_pend_reg, key_pend_next;
    logic             final_grp_reg, final_grp_next;
    logic [7:0]       key_snap_reg, key_snap_next;

    // decode store and read sequencer
    logic [23:0]      store_mem [ROWS];
    logic [7:0]       fin_reg,    fin_next;
    logic [ROW_W-1:0] rd_row_reg, rd_row_next;
    logic [1:0]       rd_lane_reg, rd_lane_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg,  out_byte_next;
    logic             out_last_reg,  out_last_next;

    logic [7:0]       enc_byte;
    logic [23:0]      enc_ins;
    logic [23:0]      enc_key_ins;
    logic             enc_final;
    logic             enc_close;
    logic [5:0]       dec_sext;
    logic [23:0]      dec_ins;
    logic             dec_final;
    logic [ROW_W-1:0] wr_row;
    logic             store_wr;
    logic [23:0]      rd_word_reg;
    logic [7:0]       rd_byte;
    logic             rd_last;
    logic             slot_free;

    assign enc_final = (pos_reg == POS_W'(ENC_LAST_POS));
    assign enc_close = (lane3_reg == 2'd2) || enc_final;
    assign dec_final = (pos_reg == POS_W'(DEC_LAST_POS));
    assign wr_row    = ROW_W'(pos_reg >> 2);
    assign enc_byte  = in_byte ^ key_byte;
    assign dec_sext  = char_to_sextet(in_byte);
    assign slot_free = !out_valid_reg || out_ready;
    assign rd_last   = (rd_row_reg == ROW_W'(RD_LAST_ROW)) && (rd_lane_reg == 2'(RD_LAST_LANE));
    assign store_wr  = cmd.take && (direction == DIR_DECODE) && (pos_reg[1:0] == 2'd3);

    // byte placed little-endian in its group
    always_comb
    begin
        unique case (lane3_reg)
            2'd0:    enc_ins = acc_reg | {16'b0, enc_byte};
            2'd1:    enc_ins = acc_reg | {8'b0, enc_byte, 8'b0};
            2'd2:    enc_ins = acc_reg | {enc_byte, 16'b0};
            default: enc_ins = acc_reg;
        endcase
        // key appended behind a short final group
        unique case (lane3_reg)
            2'd0:    enc_key_ins = enc_ins | {8'b0, key_byte, 8'b0};
            2'd1:    enc_key_ins = enc_ins | {key_byte, 16'b0};
            default: enc_key_ins = enc_ins;
        endcase
        unique case (pos_reg[1:0])
            2'd0: dec_ins = acc_reg | {18'b0, dec_sext};
            2'd1: dec_ins = acc_reg | {12'b0, dec_sext, 6'b0};
            2'd2: dec_ins = acc_reg | {6'b0, dec_sext, 12'b0};
            2'd3: dec_ins = acc_reg | {dec_sext, 18'b0};
        endcase
        unique case (rd_lane_reg)
            2'd0:    rd_byte = rd_word_reg[7:0];
            2'd1:    rd_byte = rd_word_reg[15:8];
            default: rd_byte = rd_word_reg[23:16];
        endcase
    end

    always_comb
    begin
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        lane3_next     = lane3_reg;
        shift_next     = shift_reg;
        sext_next      = sext_reg;
        key_pend_next  = key_pend_reg;
        final_grp_next = final_grp_reg;
        key_snap_next  = key_snap_reg;
        fin_next       = fin_reg;
        rd_row_next    = rd_row_reg;
        rd_lane_next   = rd_lane_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (clear_frame)
        begin
            acc_next   = '0;
            pos_next   = '0;
            lane3_next = '0;
        end
        else if (cmd.take && (direction == DIR_ENCODE))
        begin
            sext_next      = '0;
            key_snap_next  = key_byte;
            final_grp_next = enc_final;
            key_pend_next  = enc_final && (lane3_reg == 2'd2);
            pos_next       = enc_final ? '0 : pos_reg + 1'b1;
            if (enc_close)
            begin
                shift_next = enc_final ? enc_key_ins : enc_ins;
                acc_next   = '0;
                lane3_next = '0;
            end
            else
            begin
                acc_next   = enc_ins;
                lane3_next = lane3_reg + 2'd1;
            end
        end
        else if (cmd.take)
        begin
            rd_row_next  = '0;
            rd_lane_next = '0;
            pos_next     = dec_final ? '0 : pos_reg + 1'b1;
            if (pos_reg[1:0] == 2'd3)
            begin
                acc_next = '0;
                if (wr_row == ROW_W'(ROWS - 1))
                begin
                    fin_next = dec_ins[8*FIN_LANE +: 8];
                end
            end
            else
            begin
                acc_next = dec_ins;
            end
        end
        else if (cmd.emit && (direction == DIR_ENCODE))
        begin
            out_valid_next = 1'b1;
            out_byte_next  = sextet_to_char(shift_reg[5:0]);
            out_last_next  = (sext_reg == 2'd3) && final_grp_reg && !key_pend_reg;
            sext_next      = sext_reg + 2'd1;
            if ((sext_reg == 2'd3) && key_pend_reg)
            begin
                shift_next    = {16'b0, key_snap_reg};
                key_pend_next = 1'b0;
            end
            else
            begin
                shift_next = shift_reg >> 6;
            end
        end
        else if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = rd_byte ^ fin_reg;
            out_last_next  = rd_last;
            if (rd_lane_reg == 2'd2)
            begin
                rd_lane_next = '0;
                rd_row_next  = rd_row_reg + 1'b1;
            end
            else
            begin
                rd_lane_next = rd_lane_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            pos_reg       <= '0;
            lane3_reg     <= '0;
            sext_reg      <= '0;
            key_pend_reg  <= 1'b0;
            final_grp_reg <= 1'b0;
            rd_row_reg    <= '0;
            rd_lane_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            lane3_reg     <= lane3_next;
            sext_reg      <= sext_next;
            key_pend_reg  <= key_pend_next;
            final_grp_reg <= final_grp_next;
            rd_row_reg    <= rd_row_next;
            rd_lane_reg   <= rd_lane_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg    <= shift_next;
        key_snap_reg <= key_snap_next;
        fin_reg      <= fin_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        if (store_wr)
        begin
            store_mem[wr_row] <= dec_ins;
        end
        // read word follows the row being sequenced, new data passed through on a write
        if (store_wr && (wr_row == rd_row_next))
        begin
            rd_word_reg <= dec_ins;
        end
        else
        begin
            rd_word_reg <= store_mem[rd_row_next];
        end
    end

    always_comb
    begin
        status.burst       = (direction == DIR_DECODE) ? dec_final : enc_close;
        status.slot_free   = slot_free;
        status.frame_start = (pos_reg == '0) && (lane3_reg == 2'd0);
        if (direction == DIR_ENCODE)
        begin
            status.item_done = (sext_reg == 2'd3) && !key_pend_reg;
        end
        else
        begin
            status.item_done = rd_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire
